@@ rtl/assert_macros.svh @@
// Assertion helpers for the neighbor walker checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a implies b in the same cycle
`define CHK_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// Check that a implies b in the next cycle
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

@@ rtl/pnw_pkg.sv @@
// ----------------------------------------------------------------------------
// pnw_pkg
// Shared constants and types of the point set neighbor walker.
// ----------------------------------------------------------------------------
package pnw_pkg;
  localparam int MAX_PIXELS = 1023;
  localparam int IDX_W      = 10;
  localparam int COORD_W    = 16;
  localparam int STEP_W     = 11;
  localparam int DEPTH      = 1024;
  localparam logic [IDX_W-1:0] NO_NEIGHBOR = IDX_W'(MAX_PIXELS);
  localparam logic [COORD_W:0] CLOSE_LIMIT = (COORD_W+1)'(16);
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic [IDX_W-1:0] REG_PIXEL_COUNT = '0;
  localparam logic [IDX_W-1:0] REG_REVERSE     = IDX_W'(1);
  localparam int DIST_W = 2*(COORD_W+1)+1;
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_RDI   = 10'b0000000100,
    S_RDJ   = 10'b0000001000,
    S_CMP   = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_WR    = 10'b0001000000,
    S_STORE = 10'b0010000000,
    S_WALK  = 10'b0100000000,
    S_WCHK  = 10'b1000000000
  } state_t;
endpackage

@@ rtl/pnw_ram.sv @@
// ----------------------------------------------------------------------------
// pnw_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pnw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/point_set_neighbor_walker_top.sv @@
// ----------------------------------------------------------------------------
// point_set_neighbor_walker_top
// Point store, neighbor table build and walk query engine.
// ----------------------------------------------------------------------------
// Usage: pulse start with kind and payload while busy is low. A load (kind 0)
// stores one point in the cycle it is taken and leaves busy low, so loads may
// follow back to back; the load that completes the set starts a build. The
// build first clears the four tables, then compares every pair of points
// (S_RDI, then S_RDJ, S_CMP, S_MUL, S_WR per pair, then S_STORE per point)
// with busy high, paced by the single read port of the coordinate memories.
// A query (kind 1) walks one table read per step and shows result_index and
// found with strobe high for one cycle. busy drops in the strobe cycle, so
// the next transaction may be taken at the edge that takes the result.
// Reset clears the state and then runs a table clearing pass with busy high.
// Configuration writes belong between transactions, while busy is low. The
// receiver cannot stall: each result is valid for exactly its strobe cycle.
// Configuration: cfg_we, cfg_index (0 pixel_count, 1 reverse_order), cfg_data.
module point_set_neighbor_walker_top import pnw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic [IDX_W-1:0]          start_index,
  input  logic signed [STEP_W-1:0]  step_x,
  input  logic signed [STEP_W-1:0]  step_y,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [IDX_W-1:0]          cfg_data,
  output logic                      strobe,
  output logic [IDX_W-1:0]          result_index,
  output logic                      found
);
  state_t state;
  logic [IDX_W-1:0] pixel_count, load_counter, n, i, j, clr, idx;
  logic reverse_order;
  logic build_req;
  logic [STEP_W-1:0] sx, sy;
  logic phase_y;
  logic y_neg;
  logic signed [COORD_W-1:0] cx, cy;
  logic [DIST_W-1:0] bu, bd, bl, br, d;
  logic hu, hd, hl, hr;
  logic [IDX_W-1:0] nu, nd, nl, nr;
  logic [COORD_W:0] ax, ay;
  logic c_up, c_dn, c_lf, c_rt;

  // coordinate memories
  logic xy_we;
  logic [IDX_W-1:0] xy_waddr, xy_raddr;
  logic signed [COORD_W-1:0] xr, yr;
  // table memories: 0 up, 1 down, 2 left, 3 right
  logic t_we;
  logic [IDX_W-1:0] t_waddr, t_raddr;
  logic [IDX_W-1:0] t_wdata [4];
  logic [IDX_W-1:0] t_rdata [4];

  pnw_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_x (.clk, .we(xy_we), .waddr(xy_waddr),
    .wdata(point_x), .raddr(xy_raddr), .rdata(xr));
  pnw_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_y (.clk, .we(xy_we), .waddr(xy_waddr),
    .wdata(point_y), .raddr(xy_raddr), .rdata(yr));
  for (genvar g = 0; g < 4; g++) begin : g_tab
    pnw_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_t (.clk, .we(t_we), .waddr(t_waddr),
      .wdata(t_wdata[g]), .raddr(t_raddr), .rdata(t_rdata[g]));
  end

  logic accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign n = (pixel_count > IDX_W'(MAX_PIXELS)) ? IDX_W'(MAX_PIXELS) : pixel_count;

  logic [IDX_W-1:0] lc_eff;
  assign lc_eff = (load_counter >= n) ? '0 : load_counter;
  assign xy_we    = accept && kind == KIND_LOAD && n != '0;
  assign xy_waddr = reverse_order ? n - 1'b1 - lc_eff : lc_eff;
  assign xy_raddr = (state == S_IDLE) ? '0 : (state == S_RDI) ? i : j;

  assign t_we    = (state == S_CLEAR) || (state == S_STORE);
  assign t_waddr = (state == S_CLEAR) ? clr : i;
  assign t_wdata[0] = (state == S_CLEAR) ? NO_NEIGHBOR : nu;
  assign t_wdata[1] = (state == S_CLEAR) ? NO_NEIGHBOR : nd;
  assign t_wdata[2] = (state == S_CLEAR) ? NO_NEIGHBOR : nl;
  assign t_wdata[3] = (state == S_CLEAR) ? NO_NEIGHBOR : nr;
  assign t_raddr = accept ? start_index : idx;

  // pair compare on registered memory data
  logic signed [COORD_W:0] dx, dy;
  assign dx = {cx[COORD_W-1], cx} - {xr[COORD_W-1], xr};
  assign dy = {cy[COORD_W-1], cy} - {yr[COORD_W-1], yr};

  logic [STEP_W-1:0] step_cnt;
  logic table_sel;
  logic [IDX_W-1:0] walk_nx;
  assign step_cnt = phase_y ? sy : sx;
  assign walk_nx  = phase_y ? (table_sel ? t_rdata[1] : t_rdata[0])
                            : (table_sel ? t_rdata[2] : t_rdata[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      load_counter <= '0;
      pixel_count <= '0;
      reverse_order <= 1'b0;
      build_req <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_PIXEL_COUNT) pixel_count <= cfg_data;
        else if (cfg_index == REG_REVERSE) reverse_order <= cfg_data[0];
      end
      unique case (state)
        S_IDLE: if (accept) begin
          if (kind == KIND_LOAD) begin
            if (n != '0) begin
              if (lc_eff + 1'b1 == n) begin
                load_counter <= '0;
                build_req <= 1'b1;
                state <= S_CLEAR;
                clr <= '0;
              end else load_counter <= lc_eff + 1'b1;
            end
          end else begin
            idx <= start_index;
            sx <= step_x[STEP_W-1] ? STEP_W'(0) - step_x : step_x;
            sy <= step_y[STEP_W-1] ? STEP_W'(0) - step_y : step_y;
            table_sel <= step_x[STEP_W-1];
            y_neg <= step_y[STEP_W-1];
            phase_y <= 1'b0;
            state <= S_WCHK;
          end
        end
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IDX_W'(DEPTH-1)) begin
            i <= '0;
            build_req <= 1'b0;
            state <= build_req ? S_RDI : S_IDLE;
          end
        end
        S_RDI: begin
          j <= '0;
          hu <= 1'b0; hd <= 1'b0; hl <= 1'b0; hr <= 1'b0;
          nu <= NO_NEIGHBOR; nd <= NO_NEIGHBOR; nl <= NO_NEIGHBOR; nr <= NO_NEIGHBOR;
          state <= S_RDJ;
        end
        S_RDJ: begin
          if (j == '0) begin cx <= xr; cy <= yr; end
          state <= S_CMP;
        end
        S_CMP: begin
          ax <= dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
          ay <= dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
          c_up <= cy < yr; c_dn <= cy > yr;
          c_lf <= cx > xr; c_rt <= cx < xr;
          state <= S_MUL;
        end
        S_MUL: begin
          d <= DIST_W'(ax * ax) + DIST_W'(ay * ay);
          state <= S_WR;
        end
        S_WR: begin
          if (j != i) begin
            if (ax < CLOSE_LIMIT) begin
              if (c_up && (!hu || d < bu)) begin hu <= 1'b1; bu <= d; nu <= j; end
              if (c_dn && (!hd || d < bd)) begin hd <= 1'b1; bd <= d; nd <= j; end
            end
            if (ay < CLOSE_LIMIT) begin
              if (c_lf && (!hl || d < bl)) begin hl <= 1'b1; bl <= d; nl <= j; end
              if (c_rt && (!hr || d < br)) begin hr <= 1'b1; br <= d; nr <= j; end
            end
          end
          if (j + 1'b1 == n) begin
            state <= S_STORE;
          end else begin
            j <= j + 1'b1;
            state <= S_RDJ;
          end
        end
        S_STORE: begin
          // the four table writes for point i happen in this cycle
          if (i + 1'b1 == n) begin
            state <= S_IDLE;
          end else begin
            i <= i + 1'b1;
            state <= S_RDI;
          end
        end
        S_WCHK: begin
          // the table read for idx is issued in this state; S_WALK uses its data
          if (step_cnt == '0) begin
            if (!phase_y) begin
              phase_y <= 1'b1;
              table_sel <= y_neg;
            end else begin
              strobe <= 1'b1;
              result_index <= idx;
              found <= 1'b1;
              state <= S_IDLE;
            end
          end else if (idx >= IDX_W'(MAX_PIXELS)) begin
            strobe <= 1'b1; result_index <= NO_NEIGHBOR; found <= 1'b0;
            state <= S_IDLE;
          end else state <= S_WALK;
        end
        S_WALK: begin
          idx <= walk_nx;
          if (phase_y) sy <= sy - 1'b1; else sx <= sx - 1'b1;
          if (walk_nx >= NO_NEIGHBOR) begin
            strobe <= 1'b1; result_index <= NO_NEIGHBOR; found <= 1'b0;
            state <= S_IDLE;
          end else state <= S_WCHK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/pnw_checker.sv @@
// ----------------------------------------------------------------------------
// pnw_checker
// Port-level checks of the neighbor walker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pnw_checker import pnw_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             kind,
  input logic             strobe,
  input logic [IDX_W-1:0] result_index,
  input logic             found
);
  `CHK_NEXT(a_load_no_result, clk, rst, start && !busy && kind == KIND_LOAD, !strobe)
  `CHK_IMPL(a_fail_marker, clk, rst, strobe && !found, result_index == NO_NEIGHBOR)
  `CHK_NEXT(a_query_busy, clk, rst, start && !busy && kind == KIND_QUERY, busy)
  `CHK_NEXT(a_strobe_single, clk, rst, strobe, !strobe)
endmodule

bind point_set_neighbor_walker_top pnw_checker u_chk (.clk, .rst, .start, .busy, .kind,
  .strobe, .result_index, .found);
